@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Shared codes, command and status types for the console controller and
// datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_ATTR  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BLANK = 2'd1;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0]  ATTR_RESET  = 8'h0F;
  localparam logic [15:0] BLANK_RESET = 16'h0720;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } sweep_e;

  typedef struct packed {
    logic   accept;
    logic   sweep_run;
    sweep_e sweep_mode;
    logic   publish;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic wr_pend;
    logic out_busy;
    logic put_scroll;
  } sts_t;

endpackage

@@ rtl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// Text console controller
// Sequences the reset clearing pass, accept, clear and scroll sweeps and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    operation_i,
  input  tcw_pkg::sts_t sts_i,
  output logic          in_stall_o,
  output tcw_pkg::cmd_t cmd_o
);

  tcw_pkg::state_e state_q, state_d;
  logic            can_take;

  assign can_take = (state_q == tcw_pkg::ST_IDLE) && !sts_i.wr_pend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        if (sts_i.sweep_last) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i && can_take) begin
          if (operation_i == tcw_pkg::OP_CLEAR) begin
            state_d = tcw_pkg::ST_CLEAR;
          end else if (operation_i == tcw_pkg::OP_PUT && sts_i.put_scroll) begin
            state_d = tcw_pkg::ST_SCROLL;
          end else begin
            state_d = tcw_pkg::ST_DONE;
          end
        end
      end
      tcw_pkg::ST_CLEAR, tcw_pkg::ST_SCROLL: begin
        if (sts_i.sweep_last) state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        if (!sts_i.out_busy) state_d = tcw_pkg::ST_IDLE;
      end
      default: state_d = tcw_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    in_stall_o        = !can_take;
    cmd_o.accept      = in_valid_i && can_take;
    cmd_o.sweep_run   = 1'b0;
    cmd_o.sweep_mode  = tcw_pkg::SW_INIT;
    cmd_o.publish     = 1'b0;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        cmd_o.sweep_run = 1'b1;
      end
      tcw_pkg::ST_CLEAR: begin
        cmd_o.sweep_run  = 1'b1;
        cmd_o.sweep_mode = tcw_pkg::SW_CLEAR;
      end
      tcw_pkg::ST_SCROLL: begin
        cmd_o.sweep_run  = 1'b1;
        cmd_o.sweep_mode = tcw_pkg::SW_SCROLL;
      end
      tcw_pkg::ST_DONE: begin
        cmd_o.publish = !sts_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// Text console datapath
// Cell memory, cursor, sweep counter with two-stage copy pipe, result regs.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tcw_pkg::cmd_t cmd_i,
  output tcw_pkg::sts_t sts_o,
  input  logic [1:0]    operation_i,
  input  logic [7:0]    char_code_i,
  input  logic [10:0]   cell_index_i,
  input  logic [7:0]    text_attribute_i,
  input  logic [15:0]   blank_cell_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic [10:0]   cursor_index_o,
  output logic [15:0]   cell_data_o,
  output logic          scrolled_o
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int COLW   = $clog2(COLUMNS);
  localparam int ROWW   = $clog2(ROWS);
  localparam int CNW    = $clog2(COLUMNS + 8);
  localparam int COPY_N = (ROWS - 1) * COLUMNS;

  logic [15:0]     mem_q [CELLS];
  logic [15:0]     rd_q;
  logic            rd_en;
  logic [AW-1:0]   raddr;

  logic [AW-1:0]   cnt_q, cnt_d;
  logic            wr_pend_q, wr_pend_d;
  logic [AW-1:0]   wr_addr_q, wr_addr_d;
  logic            wr_copy_q, wr_copy_d;
  logic [15:0]     wr_val_q, wr_val_d;

  logic [COLW-1:0] col_q, col_f;
  logic [ROWW-1:0] row_q, row_f;
  logic [CNW-1:0]  col_ext, col_n;
  logic [ROWW:0]   row_n;
  logic            row_inc, put_wr, wrap, scroll;
  logic            in_range, put_we;
  logic [AW-1:0]   cur_addr;

  logic            scr_res_q, data_sel_q;
  logic            out_valid_q;
  logic [10:0]     cursor_index_q;
  logic [15:0]     cell_data_q;
  logic            scrolled_q;

  // cursor advance for a put request
  always_comb begin
    col_ext = CNW'(col_q);
    col_n   = col_ext;
    row_inc = 1'b0;
    put_wr  = 1'b0;
    case (char_code_i)
      tcw_pkg::CH_BS: begin
        if (col_q != '0) col_n = col_ext - CNW'(1);
      end
      tcw_pkg::CH_TAB: begin
        col_n = (col_ext + CNW'(8)) & ~CNW'(7);
      end
      tcw_pkg::CH_CR: begin
        col_n = '0;
      end
      tcw_pkg::CH_LF: begin
        col_n   = '0;
        row_inc = 1'b1;
      end
      default: begin
        if (char_code_i >= tcw_pkg::CH_SPACE) begin
          put_wr = 1'b1;
          col_n  = col_ext + CNW'(1);
        end
      end
    endcase
    wrap   = col_n >= CNW'(COLUMNS);
    col_f  = wrap ? '0 : col_n[COLW-1:0];
    row_n  = {1'b0, row_q} + (ROWW+1)'(row_inc | wrap);
    scroll = row_n >= (ROWW+1)'(ROWS);
    row_f  = scroll ? ROWW'(ROWS - 1) : row_n[ROWW-1:0];
  end

  assign cur_addr = AW'(32'(row_q) * COLUMNS + 32'(col_q));
  assign in_range = 32'(cell_index_i) < CELLS;
  assign put_we   = cmd_i.accept && (operation_i == tcw_pkg::OP_PUT) && put_wr;

  // sweep and read issue stage
  always_comb begin
    rd_en     = 1'b0;
    raddr     = AW'(cell_index_i);
    wr_pend_d = 1'b0;
    wr_addr_d = cnt_q;
    wr_copy_d = 1'b0;
    wr_val_d  = blank_cell_i;
    cnt_d     = '0;
    if (cmd_i.accept && operation_i == tcw_pkg::OP_READ && in_range) begin
      rd_en = 1'b1;
    end
    if (cmd_i.sweep_run) begin
      cnt_d     = AW'(cnt_q + AW'(1));
      wr_pend_d = 1'b1;
      case (cmd_i.sweep_mode)
        tcw_pkg::SW_INIT: begin
          wr_val_d = tcw_pkg::BLANK_RESET;
        end
        tcw_pkg::SW_SCROLL: begin
          if (32'(cnt_q) < COPY_N) begin
            rd_en     = 1'b1;
            raddr     = AW'(32'(cnt_q) + COLUMNS);
            wr_copy_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      mem_q[wr_addr_q] <= wr_copy_q ? rd_q : wr_val_q;
    end else if (put_we) begin
      mem_q[cur_addr] <= {text_attribute_i, char_code_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    wr_copy_q <= wr_copy_d;
    wr_val_q  <= wr_val_d;
    if (cmd_i.publish) begin
      cursor_index_q <= 11'(32'(row_q) * COLUMNS + 32'(col_q));
      cell_data_q    <= data_sel_q ? rd_q : '0;
      scrolled_q     <= scr_res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      scr_res_q   <= 1'b0;
      data_sel_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      wr_pend_q <= wr_pend_d;
      if (cmd_i.accept) begin
        scr_res_q  <= (operation_i == tcw_pkg::OP_PUT) && scroll;
        data_sel_q <= (operation_i == tcw_pkg::OP_READ) && in_range;
        if (operation_i == tcw_pkg::OP_PUT) begin
          col_q <= col_f;
          row_q <= row_f;
        end else if (operation_i == tcw_pkg::OP_CLEAR) begin
          col_q <= '0;
          row_q <= '0;
        end
      end
      out_valid_q <= cmd_i.publish || (out_valid_q && out_stall_i);
    end
  end

  assign sts_o.sweep_last = cnt_q == AW'(CELLS - 1);
  assign sts_o.wr_pend    = wr_pend_q;
  assign sts_o.out_busy   = out_valid_q && out_stall_i;
  assign sts_o.put_scroll = scroll;

  assign out_valid_o    = out_valid_q;
  assign cursor_index_o = cursor_index_q;
  assign cell_data_o    = cell_data_q;
  assign scrolled_o     = scrolled_q;

endmodule

@@ rtl/text_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// Text console writer unit
// Character-cell console with cursor, control codes, scroll and cell read.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid_i/in_stall_o   operation, char_code, cell_index
//   out      out_valid_o/out_stall_i cursor_index, cell_data, scrolled
//   cfg      cfg_valid_i/cfg_ready_o cfg_index (0 attribute, 1 blank), cfg_data
//
// Put, read and unused ops go from accept straight to the done state.
// Clear, and a put that scrolls, sweep all cells before done: one cell per
// cycle through the single write port of the cell memory.
// After reset a clearing pass blanks the memory; input is stalled
// meanwhile, and config writes are taken.
// A stalled result holds the block in its done state until it is taken.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic [7:0]                  char_code_i,
  input  logic [10:0]                 cell_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [10:0]                 cursor_index_o,
  output logic [15:0]                 cell_data_o,
  output logic                        scrolled_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i
);

  logic [7:0]    attr_q;
  logic [15:0]   blank_q;
  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q  <= tcw_pkg::ATTR_RESET;
      blank_q <= tcw_pkg::BLANK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tcw_pkg::REG_ATTR) begin
        attr_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == tcw_pkg::REG_BLANK) begin
        blank_q <= cfg_data_i;
      end
    end
  end

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .char_code_i      (char_code_i),
    .cell_index_i     (cell_index_i),
    .text_attribute_i (attr_q),
    .blank_cell_i     (blank_q),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .cursor_index_o   (cursor_index_o),
    .cell_data_o      (cell_data_o),
    .scrolled_o       (scrolled_o)
  );

endmodule
